FILE: rtl/assert_macros.svh
// assertion macros for the checker file
// expects clock and reset in the scope where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define SACL_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("sacl assertion failed");

// checked on every edge, reset included
`define SACL_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("sacl assertion failed");

`endif

FILE: rtl/sacl_pkg.sv
// types, constants and helpers for the set-associative lru cache model
// used by every module of the block but the queue; depends on nothing
`timescale 1ns / 1ps

package sacl_pkg;

   localparam int DEF_MAX_SET_BITS = 6;
   localparam int DEF_MAX_WAYS     = 8;
   localparam int DEF_TOTAL_LINES  = 512;
   localparam int MAX_BLOCK_BITS   = 16;

   localparam logic [1:0] KIND_FETCH  = 2'd0;
   localparam logic [1:0] KIND_LOAD   = 2'd1;
   localparam logic [1:0] KIND_STORE  = 2'd2;
   localparam logic [1:0] KIND_MODIFY = 2'd3;

   localparam logic [1:0] REG_SET_BITS   = 2'd0;
   localparam logic [1:0] REG_WAYS       = 2'd1;
   localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic        first_hit;
      logic        did_evict;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] evict_total;
   } rsp_type;

   typedef struct packed {
      logic [2:0] set_bits;
      logic [3:0] ways;
      logic [4:0] block_bits;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] tag;
      logic [31:0] stamp;
   } entry_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

FILE: rtl/set_assoc_lru_cache_sim_top.sv
// path: the front end splits the address and reduces the line base modulo the
// line count (F_MOD, F_FIX), then hands the job (F_PUSH) to the queue; the back end
// reads and compares the ways in turn (B_RD, B_CMP) until a hit or the last way,
// then loads the output register; a fetch skips the walk. Each end takes one transaction at a time.
// reset: a clearing pass over all TOTAL_LINES lines follows reset; req_ready stays low during it
`timescale 1ns / 1ps

module set_assoc_lru_cache_sim_top import sacl_pkg::*; #(
   parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = DEF_MAX_WAYS,
   parameter int TOTAL_LINES  = DEF_TOTAL_LINES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = (TOTAL_LINES > 1) ? $clog2(TOTAL_LINES) : 1;
   localparam int WAY_W = $clog2(MAX_WAYS + 1);
   localparam int JOB_W = 2 + 32 + IDX_W + WAY_W;

   cfg_type          cfg_ff;
   logic             clear_done;
   logic             fj_valid, fj_ready, bj_valid, bj_ready;
   logic [JOB_W-1:0] fj_data, bj_data;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{set_bits: 3'd0, ways: 4'd1, block_bits: 5'd0};
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[3:2])
            REG_SET_BITS:   cfg_ff.set_bits   <= csr_pwdata[2:0];
            REG_WAYS:       cfg_ff.ways       <= csr_pwdata[3:0];
            REG_BLOCK_BITS: cfg_ff.block_bits <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SET_BITS:   csr_prdata = {29'd0, cfg_ff.set_bits};
         REG_WAYS:       csr_prdata = {28'd0, cfg_ff.ways};
         REG_BLOCK_BITS: csr_prdata = {27'd0, cfg_ff.block_bits};
         default:        csr_prdata = '0;
      endcase
   end

   sacl_front #(
      .MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS),
      .TOTAL_LINES(TOTAL_LINES), .JOB_W(JOB_W)
   ) u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .clear_done(clear_done),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data)
   );

   sacl_fifo #(.WIDTH(JOB_W)) u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(fj_valid), .in_ready(fj_ready), .in_data(fj_data),
      .out_valid(bj_valid), .out_ready(bj_ready), .out_data(bj_data)
   );

   sacl_back #(
      .MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS),
      .TOTAL_LINES(TOTAL_LINES), .JOB_W(JOB_W)
   ) u_back (
      .clock(clock), .reset(reset), .clear_done(clear_done),
      .job_valid(bj_valid), .job_ready(bj_ready), .job_data(bj_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule

FILE: rtl/sacl_front.sv
// front end: accepts transactions, splits the address, reduces the line base
// modulo the line count by reciprocal multiplication; depends on sacl_pkg
`timescale 1ns / 1ps

module sacl_front import sacl_pkg::*; #(
   parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = DEF_MAX_WAYS,
   parameter int TOTAL_LINES  = DEF_TOTAL_LINES,
   parameter int JOB_W        = 2 + 32 + 9 + 4
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             clear_done,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             job_valid,
   input  logic             job_ready,
   output logic [JOB_W-1:0] job_data
);

   localparam int IDX_W  = (TOTAL_LINES > 1) ? $clog2(TOTAL_LINES) : 1;
   localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W  = $clog2(MAX_WAYS + 1);
   localparam int BASE_W = SET_W + WAY_W;
   localparam int MOD_W  = ((BASE_W > IDX_W) ? BASE_W : IDX_W) + 1;
   localparam int PROD_W = BASE_W + MOD_W;
   // floor(2^BASE_W / line count): the quotient estimate is low by at most one
   localparam int RECIP  = (2 ** BASE_W) / TOTAL_LINES;

   typedef enum logic [1:0] {F_IDLE, F_MOD, F_FIX, F_PUSH} fstate_type;

   fstate_type        state_ff, state_in;
   logic [1:0]        kind_ff, kind_in;
   logic [31:0]       tag_ff, tag_in;
   logic [WAY_W-1:0]  nw_ff, nw_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [BASE_W-1:0] quot_ff, quot_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;

   logic [4:0]        sb, bb;
   logic [31:0]       shifted;
   logic [SET_W-1:0]  set_val;
   logic [WAY_W-1:0]  nw_val;
   logic [PROD_W-1:0] prod;
   logic [MOD_W-1:0]  part;

   assign req_ready = (state_ff == F_IDLE) && clear_done;
   assign job_valid = (state_ff == F_PUSH);
   assign job_data  = {kind_ff, tag_ff, rem_ff, nw_ff};

   always_comb begin
      sb = ({2'b00, cfg.set_bits} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                       : {2'b00, cfg.set_bits};
      bb = (cfg.block_bits > 5'(MAX_BLOCK_BITS)) ? 5'(MAX_BLOCK_BITS) : cfg.block_bits;
      shifted = req_data.address >> bb;
      set_val = shifted[SET_W-1:0] & ~({SET_W{1'b1}} << sb);
      if (cfg.ways == 4'd0) begin
         nw_val = WAY_W'(1);
      end else if ({1'b0, cfg.ways} > 5'(MAX_WAYS)) begin
         nw_val = WAY_W'(MAX_WAYS);
      end else begin
         nw_val = WAY_W'(cfg.ways);
      end
      // base mod line count: estimate the quotient, then one corrective subtract
      prod = PROD_W'(base_ff) * PROD_W'(RECIP);
      part = MOD_W'(base_ff) - MOD_W'(quot_ff) * MOD_W'(TOTAL_LINES);
      if (part >= MOD_W'(TOTAL_LINES)) begin
         part = part - MOD_W'(TOTAL_LINES);
      end

      state_in = state_ff;
      kind_in  = kind_ff;
      tag_in   = tag_ff;
      nw_in    = nw_ff;
      base_in  = base_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid && req_ready) begin
               kind_in  = req_data.kind;
               tag_in   = req_data.address >> (6'(sb) + 6'(bb));
               nw_in    = nw_val;
               base_in  = BASE_W'(set_val) * BASE_W'(nw_val);
               state_in = F_MOD;
            end
         end
         F_MOD: begin
            quot_in  = prod[BASE_W +: BASE_W];
            state_in = F_FIX;
         end
         F_FIX: begin
            rem_in   = part[IDX_W-1:0];
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (job_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
      tag_ff  <= tag_in;
      nw_ff   <= nw_in;
      base_ff <= base_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

endmodule

FILE: rtl/sacl_fifo.sv
// two-entry queue between front and back end
// depends on nothing beyond its width parameter
`timescale 1ns / 1ps

module sacl_fifo #(
   parameter int WIDTH = 47
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: rtl/sacl_back.sv
// back end: walks the ways of a set in the line memory, fills on a miss,
// keeps stamps and running counts; depends on sacl_pkg
`timescale 1ns / 1ps

module sacl_back import sacl_pkg::*; #(
   parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = DEF_MAX_WAYS,
   parameter int TOTAL_LINES  = DEF_TOTAL_LINES,
   parameter int JOB_W        = 2 + 32 + 9 + 4
) (
   input  logic             clock,
   input  logic             reset,
   output logic             clear_done,
   input  logic             job_valid,
   output logic             job_ready,
   input  logic [JOB_W-1:0] job_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   localparam int IDX_W = (TOTAL_LINES > 1) ? $clog2(TOTAL_LINES) : 1;
   localparam int WAY_W = $clog2(MAX_WAYS + 1);

   typedef enum logic [2:0] {B_CLR, B_IDLE, B_RD, B_CMP, B_OUT} bstate_type;

   entry_type mem [TOTAL_LINES];
   entry_type rd_data_ff;

   bstate_type       state_ff, state_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic [1:0]       kind_ff, kind_in;
   logic [31:0]      tag_ff, tag_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [WAY_W-1:0] nw_ff, nw_in;
   logic [WAY_W-1:0] way_ff, way_in;
   logic             have_free_ff, have_free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             have_lru_ff, have_lru_in;
   logic [IDX_W-1:0] lru_idx_ff, lru_idx_in;
   logic [31:0]      lru_stamp_ff, lru_stamp_in;
   logic [31:0]      counter_ff, counter_in;
   logic [31:0]      hit_ff, hit_in;
   logic [31:0]      miss_ff, miss_in;
   logic [31:0]      evict_ff, evict_in;
   logic             first_hit_ff, first_hit_in;
   logic             evicted_ff, evicted_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic [IDX_W:0]   idx_next;
   logic             hit;

   assign clear_done = (state_ff != B_CLR);
   assign job_ready  = (state_ff == B_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      idx_next = {1'b0, idx_ff} + (IDX_W+1)'(1);
      if (idx_next == (IDX_W+1)'(TOTAL_LINES)) begin
         idx_next = '0;
      end
      hit = rd_data_ff.valid && (rd_data_ff.tag == tag_ff);

      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      kind_in      = kind_ff;
      tag_in       = tag_ff;
      idx_in       = idx_ff;
      nw_in        = nw_ff;
      way_in       = way_ff;
      have_free_in = have_free_ff;
      free_idx_in  = free_idx_ff;
      have_lru_in  = have_lru_ff;
      lru_idx_in   = lru_idx_ff;
      lru_stamp_in = lru_stamp_ff;
      counter_in   = counter_ff;
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      evict_in     = evict_ff;
      first_hit_in = first_hit_ff;
      evicted_in   = evicted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = '{valid: 1'b1, tag: tag_ff, stamp: counter_ff};

      unique case (state_ff)
         B_CLR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = '0;
            clr_idx_in = clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == IDX_W'(TOTAL_LINES - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (job_valid) begin
               kind_in      = job_data[JOB_W-1 -: 2];
               tag_in       = job_data[JOB_W-3 -: 32];
               idx_in       = job_data[WAY_W+IDX_W-1 : WAY_W];
               nw_in        = job_data[WAY_W-1:0];
               way_in       = '0;
               have_free_in = 1'b0;
               have_lru_in  = 1'b0;
               first_hit_in = 1'b0;
               evicted_in   = 1'b0;
               state_in     = (job_data[JOB_W-1 -: 2] == KIND_FETCH) ? B_OUT : B_RD;
            end
         end
         B_RD: begin
            state_in = B_CMP;
         end
         B_CMP: begin
            if (hit) begin
               mem_we       = 1'b1;
               first_hit_in = 1'b1;
               hit_in       = (kind_ff == KIND_MODIFY) ? sat_inc(sat_inc(hit_ff))
                                                       : sat_inc(hit_ff);
               state_in     = B_OUT;
            end else begin
               if (rd_data_ff.valid) begin
                  if (!have_lru_ff || (rd_data_ff.stamp < lru_stamp_ff)) begin
                     have_lru_in  = 1'b1;
                     lru_idx_in   = idx_ff;
                     lru_stamp_in = rd_data_ff.stamp;
                  end
               end else if (!have_free_ff) begin
                  have_free_in = 1'b1;
                  free_idx_in  = idx_ff;
               end
               if (way_ff == nw_ff - WAY_W'(1)) begin
                  // miss: invalid way first, else least recently used
                  mem_we     = 1'b1;
                  mem_waddr  = have_free_in ? free_idx_in : lru_idx_in;
                  evicted_in = !have_free_in;
                  miss_in    = sat_inc(miss_ff);
                  if (!have_free_in) begin
                     evict_in = sat_inc(evict_ff);
                  end
                  if (kind_ff == KIND_MODIFY) begin
                     hit_in = sat_inc(hit_ff);
                  end
                  state_in = B_OUT;
               end else begin
                  way_in   = way_ff + WAY_W'(1);
                  idx_in   = idx_next[IDX_W-1:0];
                  state_in = B_RD;
               end
            end
         end
         B_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{first_hit: first_hit_ff, did_evict: evicted_ff,
                                hit_total: hit_ff, miss_total: miss_ff,
                                evict_total: evict_ff};
               counter_in   = counter_ff + 32'd1;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLR;
         clr_idx_ff   <= '0;
         counter_ff   <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         evict_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         counter_ff   <= counter_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         evict_ff     <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      tag_ff       <= tag_in;
      idx_ff       <= idx_in;
      nw_ff        <= nw_in;
      way_ff       <= way_in;
      have_free_ff <= have_free_in;
      free_idx_ff  <= free_idx_in;
      have_lru_ff  <= have_lru_in;
      lru_idx_ff   <= lru_idx_in;
      lru_stamp_ff <= lru_stamp_in;
      first_hit_ff <= first_hit_in;
      evicted_ff   <= evicted_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // line memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[idx_ff];
   end

endmodule

FILE: rtl/sacl_checker.sv
// port-level checks for the cache model top level, bound to it below
// depends on sacl_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sacl_checker import sacl_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // clearing pass keeps the input closed right after reset
   `SACL_ASSERT_ALWAYS(a_closed_after_reset, $past(reset) |-> !req_ready)
   `SACL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
   // a first-lookup hit never evicts and shows a nonzero hit total; an eviction shows a nonzero eviction total
   `SACL_ASSERT(a_hit_no_evict, rsp_valid && rsp_data.first_hit |-> !rsp_data.did_evict)
   `SACL_ASSERT(a_hit_counted, rsp_valid && rsp_data.first_hit |-> rsp_data.hit_total != 0)
   `SACL_ASSERT(a_evict_counted,
      rsp_valid && rsp_data.did_evict |-> rsp_data.evict_total != 0)

endmodule

bind set_assoc_lru_cache_sim_top sacl_checker u_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

FILE: bench/set_assoc_lru_cache_sim_top_test.sv
// self-checking bench for the set-associative lru cache model: directed and random accesses
// over several geometries, predicted per access and compared field by field
// depends on sacl_pkg and set_assoc_lru_cache_sim_top
`timescale 1ns / 1ps

module set_assoc_lru_cache_sim_top_test import sacl_pkg::*;;

   localparam int LINES = DEF_TOTAL_LINES;
   localparam longint CYCLE_LIMIT = 3000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   set_assoc_lru_cache_sim_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor state
   logic [2:0]  geo_set_bits;
   logic [3:0]  geo_ways;
   logic [4:0]  geo_block_bits;
   logic        tag_valid [LINES];
   logic [31:0] tag_value [LINES];
   logic [31:0] tag_stamp [LINES];
   logic [31:0] access_clock;
   logic [31:0] hits, misses, evictions;

   rsp_type expected_rsps[$];
   int      mismatches;
   longint  cycle_count;
   int      stall_hold;
   int      idle_run;
   bit      busy_random_rsp;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic bit probe_line(input int set_idx, input logic [31:0] tag,
                                     input int nways, inout bit evicted);
      int base, idx, free_way, lru_way;
      logic [31:0] lru_stamp;
      bit have_lru;
      base = set_idx * nways;
      free_way = -1;
      lru_way = 0;
      lru_stamp = 0;
      have_lru = 0;
      for (int w = 0; w < nways; w++) begin
         idx = (base + w) % LINES;
         if (tag_valid[idx]) begin
            if (tag_value[idx] == tag) begin
               hits = bump(hits);
               tag_stamp[idx] = access_clock;
               return 1'b1;
            end
            if (!have_lru || tag_stamp[idx] < lru_stamp) begin
               have_lru = 1;
               lru_stamp = tag_stamp[idx];
               lru_way = w;
            end
         end else if (free_way < 0) begin
            free_way = w;
         end
      end
      misses = bump(misses);
      if (free_way >= 0) begin
         idx = (base + free_way) % LINES;
      end else begin
         idx = (base + lru_way) % LINES;
         evictions = bump(evictions);
         evicted = 1;
      end
      tag_valid[idx] = 1'b1;
      tag_value[idx] = tag;
      tag_stamp[idx] = access_clock;
      return 1'b0;
   endfunction

   function automatic rsp_type predict_access(input req_type r);
      rsp_type res;
      int sb, bb, nw, set_idx;
      logic [31:0] tag;
      bit first, evicted;
      sb = (geo_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : geo_set_bits;
      bb = (geo_block_bits > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : geo_block_bits;
      nw = (geo_ways == 0) ? 1 : (geo_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : geo_ways;
      set_idx = (r.address >> bb) & ((32'd1 << sb) - 1);
      tag = (sb + bb >= 32) ? 32'd0 : (r.address >> (sb + bb));
      first = 0;
      evicted = 0;
      if (r.kind != KIND_FETCH) begin
         first = probe_line(set_idx, tag, nw, evicted);
         if (r.kind == KIND_MODIFY) void'(probe_line(set_idx, tag, nw, evicted));
      end
      access_clock = access_clock + 32'd1;
      res.first_hit = first;
      res.did_evict = evicted;
      res.hit_total = hits;
      res.miss_total = misses;
      res.evict_total = evictions;
      return res;
   endfunction

   // receiver: random stalls, an occasional long idle run, plus a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         idle_run <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_ready <= 1'b0;
      end else if (idle_run > 0) begin
         idle_run <= idle_run - 1;
         rsp_ready <= 1'b0;
      end else if (busy_random_rsp) begin
         if ($urandom_range(0, 99) == 0) begin
            idle_run <= $urandom_range(10, 40);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) < 70);
         end
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %h", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.first_hit !== want.first_hit ||
                rsp_data.did_evict !== want.did_evict ||
                rsp_data.hit_total !== want.hit_total ||
                rsp_data.miss_total !== want.miss_total ||
                rsp_data.evict_total !== want.evict_total) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected hit %0d evict %0d totals %0d/%0d/%0d, got hit %0d evict %0d totals %0d/%0d/%0d",
                           want.first_hit, want.did_evict, want.hit_total,
                           want.miss_total, want.evict_total, rsp_data.first_hit,
                           rsp_data.did_evict, rsp_data.hit_total,
                           rsp_data.miss_total, rsp_data.evict_total);
            end
         end
      end
   end

   task automatic send_access(input logic [1:0] kind, input logic [31:0] address);
      req_type r;
      int gap;
      r.kind = kind;
      r.address = address;
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(predict_access(r));
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic finish_sending;
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_SET_BITS:   geo_set_bits = value[2:0];
         REG_WAYS:       geo_ways = value[3:0];
         REG_BLOCK_BITS: geo_block_bits = value[4:0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(input int sb, input int nw, input int bb);
      drain();
      write_reg(REG_SET_BITS, sb);
      write_reg(REG_WAYS, nw);
      write_reg(REG_BLOCK_BITS, bb);
   endtask

   // random addresses drawn mostly from a small tag pool so hits and evictions both occur
   function automatic logic [31:0] pick_address(input int pool);
      logic [31:0] a;
      if ($urandom_range(0, 19) == 0) return $urandom;
      a = $urandom_range(0, pool - 1);
      a = {a[15:0], 16'h0} ^ (a << 7) ^ $urandom_range(0, 255);
      if ($urandom_range(0, 3) == 0) a = a | 32'hF000_0000;
      return a;
   endfunction

   task automatic test_directed_defaults;
      send_access(KIND_FETCH, 32'h0000_0000);
      send_access(KIND_LOAD, 32'h0000_0000);
      send_access(KIND_LOAD, 32'h0000_0000);
      send_access(KIND_STORE, 32'hFFFF_FFFF);
      send_access(KIND_MODIFY, 32'h8000_0000);
      send_access(KIND_MODIFY, 32'h8000_0000);
      send_access(KIND_FETCH, 32'hFFFF_FFFF);
      finish_sending();
   endtask

   task automatic test_directed_wide;
      set_geometry(6, 8, 16);
      send_access(KIND_LOAD, 32'hFFFF_FFFF);
      send_access(KIND_LOAD, 32'h0000_0000);
      for (int i = 0; i < 9; i++) send_access(KIND_STORE, (i << 22) | 32'h0001_0000);
      send_access(KIND_MODIFY, 32'h0001_0000);
      finish_sending();
      // out-of-range register values act as the clamps
      set_geometry(7, 0, 31);
      send_access(KIND_LOAD, 32'h1234_5678);
      send_access(KIND_MODIFY, 32'h1234_5678);
      finish_sending();
      set_geometry(3, 15, 20);
      for (int i = 0; i < 10; i++) send_access(KIND_LOAD, i << 26);
      finish_sending();
   endtask

   task automatic test_random_phase(input int sb, input int nw, input int bb,
                                    input int count, input int pool);
      set_geometry(sb, nw, bb);
      for (int i = 0; i < count; i++)
         send_access($urandom_range(0, 3), pick_address(pool));
      finish_sending();
   endtask

   task automatic test_backpressure;
      set_geometry(2, 4, 4);
      stall_hold <= 300;
      for (int i = 0; i < 60; i++) begin
         req_data <= '{kind: KIND_LOAD, address: pick_address(40)};
         req_valid <= 1'b1;
         begin
            req_type r;
            do @(posedge clock); while (!req_ready);
            r = req_data;
            expected_rsps.push_back(predict_access(r));
         end
      end
      finish_sending();
   endtask

   initial begin
      clock = 1'b0;
      cycle_count = 0;
      mismatches = 0;
      stall_hold = 0;
      busy_random_rsp = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      geo_set_bits = 0;
      geo_ways = 1;
      geo_block_bits = 0;
      for (int i = 0; i < LINES; i++) begin
         tag_valid[i] = 0;
         tag_value[i] = 0;
         tag_stamp[i] = 0;
      end
      access_clock = 0;
      hits = 0;
      misses = 0;
      evictions = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_defaults();
      busy_random_rsp = 1;
      test_directed_wide();
      test_backpressure();
      test_random_phase(0, 1, 0, 150, 8);
      test_random_phase(6, 8, 16, 250, 600);
      test_random_phase(2, 4, 3, 300, 40);
      test_random_phase(1, 2, 5, 200, 12);
      test_random_phase(4, 3, 0, 200, 120);
      test_random_phase(3, 8, 10, 250, 90);
      drain();

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sacl_pkg.sv
rtl/sacl_front.sv
rtl/sacl_fifo.sv
rtl/sacl_back.sv
rtl/set_assoc_lru_cache_sim_top.sv
rtl/sacl_checker.sv
bench/set_assoc_lru_cache_sim_top_test.sv
